// ===== design/elex_pkg.sv =====
// Shared types, constants and character-class helpers for the expression lexer.
// No dependencies; imported by every design and checker file.
`default_nettype none

package elex_pkg;

  localparam int unsigned LenBits = 8;
  localparam int unsigned PosBits = 16;
  localparam int unsigned MaxRes  = 3;
  localparam int unsigned CntBits = 2;

  // character codes
  localparam logic [7:0] ChDot    = 8'h2E;
  localparam logic [7:0] ChUnder  = 8'h5F;
  localparam logic [7:0] ChStar   = 8'h2A;
  localparam logic [7:0] ChEq     = 8'h3D;
  localparam logic [7:0] ChGt     = 8'h3E;
  localparam logic [7:0] ChLt     = 8'h3C;
  localparam logic [7:0] ChBang   = 8'h21;
  localparam logic [7:0] ChColon  = 8'h3A;
  localparam logic [7:0] ChSlash  = 8'h2F;
  localparam logic [7:0] ChPct    = 8'h25;
  localparam logic [7:0] ChPlus   = 8'h2B;
  localparam logic [7:0] ChMinus  = 8'h2D;
  localparam logic [7:0] ChLParen = 8'h28;
  localparam logic [7:0] ChRParen = 8'h29;
  localparam logic [7:0] ChComma  = 8'h2C;
  localparam logic [7:0] ChLBrack = 8'h5B;
  localparam logic [7:0] ChRBrack = 8'h5D;
  localparam logic [7:0] ChLBrace = 8'h7B;
  localparam logic [7:0] ChRBrace = 8'h7D;
  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChTab    = 8'h09;
  localparam logic [7:0] ChCr     = 8'h0D;
  localparam logic [7:0] ChLf     = 8'h0A;

  typedef enum logic [4:0] {
    TOK_INT    = 5'd0,
    TOK_FLOAT  = 5'd1,
    TOK_IDENT  = 5'd2,
    TOK_POW    = 5'd3,
    TOK_MUL    = 5'd4,
    TOK_DIV    = 5'd5,
    TOK_MOD    = 5'd6,
    TOK_PLUS   = 5'd7,
    TOK_MINUS  = 5'd8,
    TOK_LPAREN = 5'd9,
    TOK_RPAREN = 5'd10,
    TOK_COMMA  = 5'd11,
    TOK_COLON  = 5'd12,
    TOK_LBRACK = 5'd13,
    TOK_RBRACK = 5'd14,
    TOK_LBRACE = 5'd15,
    TOK_RBRACE = 5'd16,
    TOK_LT     = 5'd17,
    TOK_LE     = 5'd18,
    TOK_GT     = 5'd19,
    TOK_GE     = 5'd20,
    TOK_ASSIGN = 5'd21,
    TOK_EQ     = 5'd22,
    TOK_ARROW  = 5'd23,
    TOK_NOT    = 5'd24,
    TOK_NE     = 5'd25,
    TOK_NL     = 5'd26,
    TOK_ERR    = 5'd27,
    TOK_END    = 5'd28
  } tok_type_e;

  typedef enum logic [2:0] {
    MODE_IDLE = 3'd0,
    MODE_NUM  = 3'd1,
    MODE_ID   = 3'd2,
    MODE_STAR = 3'd3,
    MODE_LT   = 3'd4,
    MODE_GT   = 3'd5,
    MODE_EQ   = 3'd6,
    MODE_BANG = 3'd7
  } lex_mode_e;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       last;
  } lex_in_t;

  typedef struct packed {
    tok_type_e          token_type;
    logic [PosBits-1:0] token_start;
    logic [LenBits-1:0] token_length;
    logic               last_result;
  } lex_tok_t;

  // all tokens raised by one character
  typedef struct packed {
    lex_tok_t [MaxRes-1:0] tok;
    logic [CntBits-1:0]    cnt;
  } tok_bundle_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_num_char(input logic [7:0] c);
    return is_digit(c) || (c == ChDot);
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A)) ||
           (c == ChUnder);
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return (c == ChSpace) || (c == ChTab) || (c == ChCr);
  endfunction

  // two-char operator from held mode and next char; TOK_INT when none
  function automatic tok_type_e pair_type(input lex_mode_e m, input logic [7:0] c);
    tok_type_e t;
    t = TOK_INT;
    case (m)
      MODE_STAR: if (c == ChStar) t = TOK_POW;
      MODE_LT:   if (c == ChEq) t = TOK_LE;
      MODE_GT:   if (c == ChEq) t = TOK_GE;
      MODE_EQ: begin
        if (c == ChEq) t = TOK_EQ;
        else if (c == ChGt) t = TOK_ARROW;
      end
      MODE_BANG: if (c == ChEq) t = TOK_NE;
      default:   t = TOK_INT;
    endcase
    return t;
  endfunction

  // type of the pending token a flush would emit
  function automatic tok_type_e flush_type(input lex_mode_e m, input logic dot);
    tok_type_e t;
    case (m)
      MODE_NUM:  t = dot ? TOK_FLOAT : TOK_INT;
      MODE_ID:   t = TOK_IDENT;
      MODE_STAR: t = TOK_MUL;
      MODE_LT:   t = TOK_LT;
      MODE_GT:   t = TOK_GT;
      MODE_EQ:   t = TOK_ASSIGN;
      MODE_BANG: t = TOK_NOT;
      default:   t = TOK_INT;
    endcase
    return t;
  endfunction

  // single-character token type of a byte that starts nothing
  function automatic tok_type_e single_type(input logic [7:0] c);
    tok_type_e t;
    case (c)
      ChSlash:  t = TOK_DIV;
      ChPct:    t = TOK_MOD;
      ChPlus:   t = TOK_PLUS;
      ChMinus:  t = TOK_MINUS;
      ChLParen: t = TOK_LPAREN;
      ChRParen: t = TOK_RPAREN;
      ChComma:  t = TOK_COMMA;
      ChColon:  t = TOK_COLON;
      ChLBrack: t = TOK_LBRACK;
      ChRBrack: t = TOK_RBRACK;
      ChLBrace: t = TOK_LBRACE;
      ChRBrace: t = TOK_RBRACE;
      ChLf:     t = TOK_NL;
      default:  t = TOK_ERR;
    endcase
    return t;
  endfunction

endpackage

`default_nettype wire

// ===== design/elex_front.sv =====
// Front end: accepts one character a cycle, keeps lexing state, builds token bundles.
// Input stalls while the queue is full. Depends on elex_pkg.
`default_nettype none

module elex_front
  import elex_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  input  wire lex_in_t     in_data_i,
  output logic             in_stall_o,
  input  wire logic        q_full_i,
  output logic             push_o,
  output tok_bundle_t      bundle_o
);

  lex_mode_e          mode_q, mode_d;
  logic               dot_q, dot_d;
  logic [LenBits-1:0] len_q, len_d;
  logic [PosBits-1:0] start_q, start_d;
  logic [PosBits-1:0] pos_q, pos_d;
  logic               accept;

  tok_bundle_t        bnd;
  logic [CntBits-1:0] cnt;
  logic               used;
  logic [7:0]         c;
  logic [PosBits-1:0] p;
  tok_type_e          pt;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;

  always_comb begin
    mode_d  = mode_q;
    dot_d   = dot_q;
    len_d   = len_q;
    start_d = start_q;
    pos_d   = pos_q;
    bnd     = '0;
    cnt     = '0;
    used    = 1'b0;
    c       = in_data_i.char_byte;
    p       = pos_q;
    pt      = pair_type(mode_q, c);

    // resolve the pending token against this character
    if (mode_q >= MODE_STAR) begin
      bnd.tok[cnt].token_start = start_q;
      if (pt != TOK_INT) begin
        bnd.tok[cnt].token_type   = pt;
        bnd.tok[cnt].token_length = LenBits'(2);
        used = 1'b1;
      end else begin
        bnd.tok[cnt].token_type   = flush_type(mode_q, dot_q);
        bnd.tok[cnt].token_length = LenBits'(1);
      end
      cnt    = cnt + 1'b1;
      mode_d = MODE_IDLE;
      dot_d  = 1'b0;
      len_d  = '0;
    end else if (mode_q != MODE_IDLE) begin
      if ((mode_q == MODE_NUM && is_num_char(c)) || (mode_q == MODE_ID && is_letter(c))) begin
        if (c == ChDot) dot_d = 1'b1;
        if (len_q != '1) len_d = len_q + 1'b1;
        used = 1'b1;
      end else begin
        bnd.tok[cnt].token_type   = flush_type(mode_q, dot_q);
        bnd.tok[cnt].token_start  = start_q;
        bnd.tok[cnt].token_length = len_q;
        cnt    = cnt + 1'b1;
        mode_d = MODE_IDLE;
        dot_d  = 1'b0;
        len_d  = '0;
      end
    end

    // character opens something new
    if (!used && !is_blank(c)) begin
      if (is_num_char(c) || is_letter(c)) begin
        mode_d  = is_letter(c) ? MODE_ID : MODE_NUM;
        dot_d   = (c == ChDot);
        start_d = p;
        len_d   = LenBits'(1);
      end else if (c == ChStar || c == ChLt || c == ChGt || c == ChEq || c == ChBang) begin
        case (c)
          ChStar:  mode_d = MODE_STAR;
          ChLt:    mode_d = MODE_LT;
          ChGt:    mode_d = MODE_GT;
          ChEq:    mode_d = MODE_EQ;
          default: mode_d = MODE_BANG;
        endcase
        start_d = p;
      end else begin
        bnd.tok[cnt].token_type   = single_type(c);
        bnd.tok[cnt].token_start  = p;
        bnd.tok[cnt].token_length = LenBits'(1);
        cnt = cnt + 1'b1;
      end
    end

    // end of text: flush and close
    if (in_data_i.last) begin
      if (mode_d != MODE_IDLE) begin
        bnd.tok[cnt].token_type   = flush_type(mode_d, dot_d);
        bnd.tok[cnt].token_start  = start_d;
        bnd.tok[cnt].token_length = (mode_d >= MODE_STAR) ? LenBits'(1) : len_d;
        cnt = cnt + 1'b1;
      end
      bnd.tok[cnt].token_type   = TOK_END;
      bnd.tok[cnt].token_start  = p + 1'b1;
      bnd.tok[cnt].token_length = '0;
      cnt     = cnt + 1'b1;
      mode_d  = MODE_IDLE;
      dot_d   = 1'b0;
      len_d   = '0;
      start_d = '0;
      pos_d   = '0;
    end else begin
      pos_d = p + 1'b1;
    end

    if (cnt != '0) bnd.tok[cnt - 1'b1].last_result = 1'b1;
    bnd.cnt = cnt;
  end

  assign push_o   = accept && (cnt != '0);
  assign bundle_o = bnd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_IDLE;
      dot_q   <= 1'b0;
      len_q   <= '0;
      start_q <= '0;
      pos_q   <= '0;
    end else if (accept) begin
      mode_q  <= mode_d;
      dot_q   <= dot_d;
      len_q   <= len_d;
      start_q <= start_d;
      pos_q   <= pos_d;
    end
  end

endmodule

`default_nettype wire

// ===== design/elex_queue.sv =====
// Short bundle queue between front and back ends.
// Depends on elex_pkg.
`default_nettype none

module elex_queue
  import elex_pkg::*;
#(
  parameter int unsigned Depth = 4
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         push_i,
  input  wire tok_bundle_t  push_data_i,
  output logic              full_o,
  input  wire logic         pop_i,
  output logic              valid_o,
  output tok_bundle_t       head_o
);

  localparam int unsigned AddrBits = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CountBits = $clog2(Depth + 1);
  localparam logic [AddrBits-1:0] LastAddr = AddrBits'(Depth - 1);

  tok_bundle_t           mem_q [Depth];
  logic [AddrBits-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CountBits-1:0]  count_q;
  logic                  do_push, do_pop;

  assign full_o  = (count_q == CountBits'(Depth));
  assign valid_o = (count_q != '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) wr_ptr_q <= (wr_ptr_q == LastAddr) ? '0 : wr_ptr_q + 1'b1;
      if (do_pop)  rd_ptr_q <= (rd_ptr_q == LastAddr) ? '0 : rd_ptr_q + 1'b1;
      if (do_push && !do_pop) count_q <= count_q + 1'b1;
      else if (do_pop && !do_push) count_q <= count_q - 1'b1;
    end
  end

endmodule

`default_nettype wire

// ===== design/elex_back.sv =====
// Back end: unpacks token bundles into one token per cycle behind an output register.
// The output holds while out_stall_i is high. Depends on elex_pkg.
`default_nettype none

module elex_back
  import elex_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         q_valid_i,
  input  wire tok_bundle_t  q_head_i,
  output logic              q_pop_o,
  output logic              out_valid_o,
  input  wire logic         out_stall_i,
  output lex_tok_t          out_data_o
);

  tok_bundle_t        bnd_q;
  logic               bvalid_q;
  logic [CntBits-1:0] idx_q;
  logic               out_valid_q;
  lex_tok_t           out_q;
  logic               load_out, take, finish, refill;

  assign load_out = !out_valid_q || !out_stall_i;
  assign take     = load_out && bvalid_q;
  assign finish   = take && (idx_q == bnd_q.cnt - 1'b1);
  assign refill   = !bvalid_q || finish;
  assign q_pop_o  = refill && q_valid_i;

  always_ff @(posedge clk_i) begin
    if (q_pop_o) bnd_q <= q_head_i;
    if (take)    out_q <= bnd_q.tok[idx_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bvalid_q    <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (load_out) out_valid_q <= bvalid_q;
      if (refill)   bvalid_q <= q_valid_i;
      if (q_pop_o)  idx_q <= '0;
      else if (take) idx_q <= idx_q + 1'b1;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

// ===== design/expression_lexer_core.sv =====
// Expression lexer top level: front end, bundle queue and back end.
// Depends on elex_pkg, elex_front, elex_queue, elex_back.
//
//   channel | dir | handshake             | payload
//   --------+-----+-----------------------+---------------------------------------
//   in      | in  | in_valid_i/in_stall_o | lex_in_t: char_byte, last
//   out     | out | out_valid_o/out_stall_i| lex_tok_t: type, start, length, last
//
// One character is taken per cycle while the bundle queue has room; the front end
// updates its lexing state in that same cycle and pushes all tokens (up to three)
// raised by the character as one bundle. The back end sends one token per cycle
// unless the output stalls, so sustained input rate is one character per cycle as
// long as tokens average at most one per character; the output register is the
// limit beyond that.
// Reset clears lexing state, position, queue pointers and valid flags; no sweep.
// A stalled output only fills the queue; input stalls once QUEUE_DEPTH bundles wait.
`default_nettype none

module expression_lexer_core
  import elex_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  input  wire lex_in_t  in_data_i,
  output logic          in_stall_o,
  output logic          out_valid_o,
  input  wire logic     out_stall_i,
  output lex_tok_t      out_data_o
);

  // front -> queue
  logic        push;
  tok_bundle_t push_bundle;
  logic        q_full;
  // queue -> back
  logic        q_valid;
  tok_bundle_t q_head;
  logic        q_pop;

  elex_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_data_i  (in_data_i),
    .in_stall_o (in_stall_o),
    .q_full_i   (q_full),
    .push_o     (push),
    .bundle_o   (push_bundle)
  );

  elex_queue #(
    .Depth (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_bundle),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .head_o      (q_head)
  );

  elex_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_head_i    (q_head),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

// ===== design/elex_checker.sv =====
// Port-level checks on the lexer output stream, bound to the top level.
// Depends on elex_pkg and expression_lexer_core.
`default_nettype none

module elex_checker
  import elex_pkg::*;
(
  input wire logic     clk_i,
  input wire logic     rst_ni,
  input wire logic     out_valid_o,
  input wire logic     out_stall_i,
  input wire lex_tok_t out_data_o
);

  // stalled token holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("output token changed while stalled");

  // end token closes the bundle and is empty
  a_end_tok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.token_type == TOK_END |->
      out_data_o.last_result && out_data_o.token_length == '0)
    else $error("end token malformed");

  // two-character operators have length two
  a_pair_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.token_type == TOK_POW || out_data_o.token_type == TOK_LE ||
      out_data_o.token_type == TOK_GE || out_data_o.token_type == TOK_EQ ||
      out_data_o.token_type == TOK_ARROW || out_data_o.token_type == TOK_NE) |->
      out_data_o.token_length == LenBits'(2))
    else $error("pair operator length");

  // runs are never empty
  a_run_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.token_type != TOK_END |-> out_data_o.token_length != '0)
    else $error("zero-length token");

endmodule

bind expression_lexer_core elex_checker u_elex_checker (.*);

`default_nettype wire

// ===== verif/expression_lexer_core_test.sv =====
// Self-checking bench for expression_lexer_core: character requests in, tokens out.
// Depends on elex_pkg and the lexer RTL; an in-bench tokeniser predicts most tokens.
// Stimulus: a directed table (some rows with hand-typed tokens), then random short texts.
`default_nettype none

module expression_lexer_core_test;
  import elex_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // ---------------------------------------------------------------------------
  // Clock, reset and the two channels
  // ---------------------------------------------------------------------------
  logic     clk_i       = 1'b0;
  logic     rst_ni      = 1'b0;
  logic     in_valid_i  = 1'b0;
  lex_in_t  in_data_i   = '0;
  logic     in_stall_o;
  logic     out_valid_o;
  logic     out_stall_i = 1'b0;
  lex_tok_t out_data_o;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  expression_lexer_core DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_data_i   (in_data_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // idling knobs, percent per cycle; changed between phases only
  int gap_pct   = 0;
  int stall_pct = 0;

  // ---------------------------------------------------------------------------
  // Tokeniser state: mirrors the lexer's pending run and character position
  // ---------------------------------------------------------------------------
  lex_mode_e          run_mode = MODE_IDLE;
  logic               run_dot  = 1'b0;
  logic [LenBits-1:0] run_len  = '0;
  logic [PosBits-1:0] run_from = '0;
  logic [PosBits-1:0] next_pos = '0;

  lex_tok_t char_tokens[$];     // tokens raised by the character just taken
  lex_tok_t pending_tokens[$];  // tokens still owed by the lexer, oldest first
  int       fault_count = 0;

  function automatic void note_fault(input string what);
    fault_count++;
    if (fault_count <= 10) $display("%s", what);
  endfunction

  function automatic logic num_char(input logic [7:0] c);
    return (c >= "0" && c <= "9") || c == ChDot;
  endfunction

  function automatic logic word_char(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == ChUnder;
  endfunction

  function automatic void add_token(input tok_type_e t, input logic [PosBits-1:0] at,
                                    input logic [LenBits-1:0] len);
    lex_tok_t k;
    k.token_type   = t;
    k.token_start  = at;
    k.token_length = len;
    k.last_result  = 1'b0;
    char_tokens.push_back(k);
  endfunction

  // Emit whatever is pending; a held operator with no partner goes out alone.
  function automatic void close_run();
    case (run_mode)
      MODE_NUM:  add_token(run_dot ? TOK_FLOAT : TOK_INT, run_from, run_len);
      MODE_ID:   add_token(TOK_IDENT, run_from, run_len);
      MODE_STAR: add_token(TOK_MUL, run_from, LenBits'(1));
      MODE_LT:   add_token(TOK_LT, run_from, LenBits'(1));
      MODE_GT:   add_token(TOK_GT, run_from, LenBits'(1));
      MODE_EQ:   add_token(TOK_ASSIGN, run_from, LenBits'(1));
      MODE_BANG: add_token(TOK_NOT, run_from, LenBits'(1));
      default: ;
    endcase
    run_mode = MODE_IDLE;
    run_dot  = 1'b0;
    run_len  = '0;
  endfunction

  // Does c complete the held operator? t gets the two-character type if so.
  function automatic logic completes_pair(input logic [7:0] c, output tok_type_e t);
    logic hit;
    hit = 1'b1;
    t   = TOK_ERR;
    if (run_mode == MODE_STAR && c == ChStar) t = TOK_POW;
    else if (run_mode == MODE_LT && c == ChEq) t = TOK_LE;
    else if (run_mode == MODE_GT && c == ChEq) t = TOK_GE;
    else if (run_mode == MODE_EQ && c == ChEq) t = TOK_EQ;
    else if (run_mode == MODE_EQ && c == ChGt) t = TOK_ARROW;
    else if (run_mode == MODE_BANG && c == ChEq) t = TOK_NE;
    else hit = 1'b0;
    return hit;
  endfunction

  // A character that nothing pending has absorbed.
  function automatic void begin_char(input logic [7:0] c, input logic [PosBits-1:0] p);
    if (c == ChSpace || c == ChTab || c == ChCr) return;
    if (num_char(c)) begin
      run_mode = MODE_NUM;
      run_dot  = (c == ChDot);
      run_from = p;
      run_len  = LenBits'(1);
      return;
    end
    if (word_char(c)) begin
      run_mode = MODE_ID;
      run_dot  = 1'b0;
      run_from = p;
      run_len  = LenBits'(1);
      return;
    end
    case (c)
      ChStar:   begin run_mode = MODE_STAR; run_from = p; end
      ChLt:     begin run_mode = MODE_LT;   run_from = p; end
      ChGt:     begin run_mode = MODE_GT;   run_from = p; end
      ChEq:     begin run_mode = MODE_EQ;   run_from = p; end
      ChBang:   begin run_mode = MODE_BANG; run_from = p; end
      ChSlash:  add_token(TOK_DIV, p, LenBits'(1));
      ChPct:    add_token(TOK_MOD, p, LenBits'(1));
      ChPlus:   add_token(TOK_PLUS, p, LenBits'(1));
      ChMinus:  add_token(TOK_MINUS, p, LenBits'(1));
      ChLParen: add_token(TOK_LPAREN, p, LenBits'(1));
      ChRParen: add_token(TOK_RPAREN, p, LenBits'(1));
      ChComma:  add_token(TOK_COMMA, p, LenBits'(1));
      ChColon:  add_token(TOK_COLON, p, LenBits'(1));
      ChLBrack: add_token(TOK_LBRACK, p, LenBits'(1));
      ChRBrack: add_token(TOK_RBRACK, p, LenBits'(1));
      ChLBrace: add_token(TOK_LBRACE, p, LenBits'(1));
      ChRBrace: add_token(TOK_RBRACE, p, LenBits'(1));
      ChLf:     add_token(TOK_NL, p, LenBits'(1));
      default:  add_token(TOK_ERR, p, LenBits'(1));
    endcase
  endfunction

  // Advance the tokeniser by one character; char_tokens gets what it raises.
  function automatic void tokenise_char(input logic [7:0] c, input logic fin);
    logic [PosBits-1:0] p;
    logic               taken;
    tok_type_e          pt;
    lex_tok_t           tail;
    char_tokens.delete();
    p     = next_pos;
    taken = 1'b0;
    if (run_mode >= MODE_STAR) begin
      if (completes_pair(c, pt)) begin
        add_token(pt, run_from, LenBits'(2));
        run_mode = MODE_IDLE;
        taken    = 1'b1;
      end else begin
        close_run();
      end
    end else if (run_mode == MODE_NUM) begin
      if (num_char(c)) begin
        if (c == ChDot) run_dot = 1'b1;
        if (run_len != '1) run_len++;   // length sticks at all ones
        taken = 1'b1;
      end else begin
        close_run();
      end
    end else if (run_mode == MODE_ID) begin
      if (word_char(c)) begin
        if (run_len != '1) run_len++;
        taken = 1'b1;
      end else begin
        close_run();
      end
    end
    if (!taken) begin_char(c, p);
    if (fin) begin
      // end of text: flush, end token one past the last character, start over at 0
      close_run();
      add_token(TOK_END, p + 1'b1, LenBits'(0));
      run_from = '0;
      next_pos = '0;
    end else begin
      next_pos = p + 1'b1;
    end
    if (char_tokens.size() > 0) begin
      tail = char_tokens.pop_back();
      tail.last_result = 1'b1;
      char_tokens.push_back(tail);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Directed table. Rows with typed >= 0 carry that many hand-written tokens,
  // taken in order from known_tokens; typed < 0 means the tokeniser decides.
  // ---------------------------------------------------------------------------
  typedef struct {
    logic [7:0] ch;
    logic       fin;
    int         typed;
  } script_row_t;

  script_row_t script [29] = '{
    '{ChLParen, 1'b0,  1},  // single punctuation straight after reset
    '{8'h00,    1'b0,  1},  // NUL is unknown
    '{8'hFF,    1'b0,  1},  // top byte is unknown
    '{ChStar,   1'b0, -1},
    '{ChStar,   1'b0,  1},  // power
    '{"1",      1'b0, -1},
    '{ChDot,    1'b0, -1},
    '{"2",      1'b0, -1},
    '{ChDot,    1'b0, -1},  // two dots, still one float
    '{"a",      1'b0, -1},
    '{"7",      1'b0, -1},  // digit cuts the identifier short
    '{ChLt,     1'b0, -1},
    '{ChEq,     1'b0, -1},
    '{ChGt,     1'b0, -1},
    '{ChStar,   1'b0, -1},  // lone greater-than, new held star
    '{ChSlash,  1'b0, -1},  // lone star and a divide from one character
    '{ChEq,     1'b0, -1},
    '{ChGt,     1'b0, -1},  // arrow
    '{ChBang,   1'b0, -1},
    '{ChEq,     1'b0, -1},
    '{ChEq,     1'b0, -1},
    '{ChEq,     1'b0, -1},
    '{ChBang,   1'b0, -1},
    '{ChUnder,  1'b0, -1},  // lone bang, underscore opens an identifier
    '{ChTab,    1'b0, -1},  // whitespace closes the run silently
    '{ChDot,    1'b1, -1},  // bare dot as last character
    '{ChEq,     1'b0,  0},  // new text from position 0, operator held
    '{ChPlus,   1'b1,  3},  // three tokens from one character
    '{ChLf,     1'b1,  2}
  };

  lex_tok_t known_tokens [9] = '{
    '{TOK_LPAREN, 16'd0, 8'd1, 1'b1},
    '{TOK_ERR,    16'd1, 8'd1, 1'b1},
    '{TOK_ERR,    16'd2, 8'd1, 1'b1},
    '{TOK_POW,    16'd3, 8'd2, 1'b1},
    '{TOK_ASSIGN, 16'd0, 8'd1, 1'b0},
    '{TOK_PLUS,   16'd1, 8'd1, 1'b0},
    '{TOK_END,    16'd2, 8'd0, 1'b1},
    '{TOK_NL,     16'd0, 8'd1, 1'b0},
    '{TOK_END,    16'd1, 8'd0, 1'b1}
  };
  int known_at = 0;

  // ---------------------------------------------------------------------------
  // Request side. Each call raises valid (after idle cycles drawn one by one),
  // holds the payload until taken, then books the tokens that the character owes.
  // ---------------------------------------------------------------------------
  task automatic send_char(input logic [7:0] ch, input logic fin, input int typed);
    lex_in_t req;
    req.char_byte = ch;
    req.last      = fin;
    while (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    tokenise_char(ch, fin);
    if (typed < 0) begin
      foreach (char_tokens[j]) pending_tokens.push_back(char_tokens[j]);
    end else begin
      repeat (typed) begin
        pending_tokens.push_back(known_tokens[known_at]);
        known_at++;
      end
    end
  endtask

  // Pause the request side until every owed token has come out.
  task automatic hold_until_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_tokens.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [7:0] pick(input string s);
    return s[$urandom_range(0, s.len() - 1)];
  endfunction

  // Short texts built from plausible fragments, with some raw noise bytes.
  task automatic random_texts(input int budget);
    int         sent;
    int         len;
    int         kind;
    logic [7:0] text[$];
    sent = 0;
    while (sent < budget) begin
      text.delete();
      len = $urandom_range(3, 30);
      while (text.size() < len) begin
        kind = $urandom_range(0, 99);
        if (kind < 22) begin
          repeat ($urandom_range(1, 6))
            text.push_back(($urandom_range(0, 4) == 0) ? ChDot : pick("0123456789"));
        end else if (kind < 44) begin
          repeat ($urandom_range(1, 8))
            text.push_back(pick("abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_"));
        end else if (kind < 62) begin
          text.push_back(pick("*<>=!"));
          if ($urandom_range(0, 9) < 6) text.push_back(pick("=>*"));
        end else if (kind < 74) begin
          text.push_back(pick("/%+-(),:[]{}"));
        end else if (kind < 84) begin
          text.push_back(pick(" \t\r"));
        end else if (kind < 90) begin
          text.push_back(ChLf);
        end else begin
          text.push_back(8'($urandom_range(0, 255)));
        end
      end
      foreach (text[j]) send_char(text[j], j == text.size() - 1, -1);
      sent += text.size();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Token side: random stall, and every accepted token checked in order
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) out_stall_i <= ($urandom_range(0, 99) < stall_pct);

  always @(posedge clk_i) begin
    lex_tok_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_tokens.size() == 0) begin
        note_fault($sformatf("unexpected token: type %0d start %0d len %0d last %0b",
                             out_data_o.token_type, out_data_o.token_start,
                             out_data_o.token_length, out_data_o.last_result));
      end else begin
        want = pending_tokens.pop_front();
        if (out_data_o.token_type !== want.token_type ||
            out_data_o.token_start !== want.token_start ||
            out_data_o.token_length !== want.token_length ||
            out_data_o.last_result !== want.last_result)
          note_fault($sformatf({"token mismatch: expected type %0d start %0d len %0d last %0b,",
                                " got type %0d start %0d len %0d last %0b"},
                               want.token_type, want.token_start, want.token_length,
                               want.last_result, out_data_o.token_type,
                               out_data_o.token_start, out_data_o.token_length,
                               out_data_o.last_result));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Run sequence
  // ---------------------------------------------------------------------------
  initial begin
    int spin;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // sender idles more lightly than the receiver stalls
    gap_pct   = 35;
    stall_pct = 47;
    foreach (script[i]) send_char(script[i].ch, script[i].fin, script[i].typed);
    hold_until_drained();
    random_texts(130);
    hold_until_drained();

    // the other way round
    gap_pct   = 47;
    stall_pct = 35;
    random_texts(130);
    hold_until_drained();

    // full rate on both sides
    gap_pct   = 0;
    stall_pct = 0;
    random_texts(80);

    in_valid_i <= 1'b0;
    spin = 0;
    @(posedge clk_i);
    while (pending_tokens.size() != 0 && spin < 5000) begin
      @(posedge clk_i);
      spin++;
    end
    if (pending_tokens.size() != 0)
      note_fault($sformatf("%0d tokens never arrived", pending_tokens.size()));
    repeat (8) @(posedge clk_i);   // catch stray tokens after the last one owed

    if (fault_count == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #24_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

`default_nettype wire
